// ----- hdl/pjd_pkg.sv -----
// shared constants, types and command/status structs for the job dispatch block
// no dependencies; used by pjd_ctrl, pjd_dpath and the top level
`timescale 1ns / 1ps
`default_nettype none
package pjd_pkg;

	localparam int WORKERS  = 8;
	localparam int MAX_JOBS = 32;
	localparam int W_BITS   = $clog2(WORKERS);
	localparam int J_BITS   = $clog2(MAX_JOBS);
	localparam int CNT_BITS = $clog2(MAX_JOBS + 1);

	localparam int REQ_W   = 11;
	localparam int MIN_W   = 8;
	localparam int RATE_W  = 8;
	localparam int TIME_W  = 16;
	localparam int EARN_W  = 21;
	localparam int PROD_W  = MIN_W + RATE_W;
	localparam int IDX_W   = 5;
	localparam int WID_W   = 3;
	localparam int JOB_W   = REQ_W + MIN_W + 1;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 72;
	localparam int CFG_W    = 11;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [EARN_W-1:0] EARN_MAX = '1;

	localparam logic [REQ_W-1:0]  START_RESET = 11'd780;
	localparam logic [RATE_W-1:0] RATE_RESET  = 8'd21;

	// configuration register indexes
	localparam logic CFG_START = 1'b0;
	localparam logic CFG_RATE  = 1'b1;

	typedef struct packed {
		logic load;       // input request accepted
		logic init_step;  // write one worker's initial state
		logic rd;         // read job store at current job
		logic next_job;   // step to next job
		logic next_pass;  // restart job scan for ordinary jobs
		logic scan_start; // begin earliest-free worker search
		logic scan_step;  // look at one worker
		logic calc;       // start time and pay product
		logic upd;        // worker update and result capture
		logic done;       // batch finished
	} pjd_cmd_t;

	typedef struct packed {
		logic at_end;
		logic pass1;
		logic skip_job;
		logic w_last;
	} pjd_sts_t;

endpackage
`default_nettype wire

// ----- hdl/pjd_ctrl.sv -----
// dispatch controller: one-hot state machine sequencing load, worker init,
// job scan, worker search and result handoff; uses pjd_pkg
`timescale 1ns / 1ps
`default_nettype none
module pjd_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	input  wire               s_tlast,
	output logic              s_tready,
	output logic              m_tvalid,
	input  wire               m_tready,
	input  pjd_pkg::pjd_sts_t sts,
	output pjd_pkg::pjd_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_LOAD = 8'b0000_0001,
		S_INIT = 8'b0000_0010,
		S_RD   = 8'b0000_0100,
		S_CHK  = 8'b0000_1000,
		S_SCAN = 8'b0001_0000,
		S_CALC = 8'b0010_0000,
		S_UPD  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_LOAD);
	assign m_tvalid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_LOAD: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (s_tlast) state_d = S_INIT;
				end
			end
			S_INIT: begin
				cmd.init_step = 1'b1;
				if (sts.w_last) state_d = S_RD;
			end
			S_RD: begin
				if (sts.at_end) begin
					if (sts.pass1) begin
						cmd.done = 1'b1;
						state_d  = S_LOAD;
					end else begin
						cmd.next_pass = 1'b1;
					end
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.skip_job) begin
					cmd.next_job = 1'b1;
					state_d      = S_RD;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.w_last) state_d = S_CALC;
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (m_tready) begin
					cmd.next_job = 1'b1;
					state_d      = S_RD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_LOAD;
		else         state_q <= state_d;
	end

endmodule
`default_nettype wire

// ----- hdl/pjd_dpath.sv -----
// dispatch datapath: job store, worker free times and earnings, config
// registers, scan counters and result register; uses pjd_pkg
`timescale 1ns / 1ps
`default_nettype none
module pjd_dpath (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  pjd_pkg::pjd_cmd_t                   cmd,
	output pjd_pkg::pjd_sts_t                   sts,
	input  wire                                 cfg_valid,
	input  wire                                 cfg_index,
	input  wire  [pjd_pkg::CFG_W-1:0]           cfg_data,
	input  wire  [pjd_pkg::S_DATA_W-1:0]        s_tdata,
	input  wire                                 s_tuser,
	input  wire                                 s_tlast,
	output logic [pjd_pkg::M_DATA_W-1:0]        m_tdata,
	output logic                                m_tuser,
	output logic                                m_tlast
);

	localparam int REQ_W  = pjd_pkg::REQ_W;
	localparam int MIN_W  = pjd_pkg::MIN_W;
	localparam int TIME_W = pjd_pkg::TIME_W;
	localparam int EARN_W = pjd_pkg::EARN_W;
	localparam int PROD_W = pjd_pkg::PROD_W;
	localparam int W_BITS = pjd_pkg::W_BITS;
	localparam int J_BITS = pjd_pkg::J_BITS;
	localparam int CNT_BITS = pjd_pkg::CNT_BITS;

	// configuration
	logic [REQ_W-1:0]          start_cfg_q;
	logic [pjd_pkg::RATE_W-1:0] rate_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_cfg_q <= pjd_pkg::START_RESET;
			rate_cfg_q  <= pjd_pkg::RATE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == pjd_pkg::CFG_START) start_cfg_q <= cfg_data;
			if (cfg_index == pjd_pkg::CFG_RATE)
				rate_cfg_q <= cfg_data[pjd_pkg::RATE_W-1:0];
		end
	end

	// job store: {urgent, minutes, request}
	logic [pjd_pkg::JOB_W-1:0] job_mem [pjd_pkg::MAX_JOBS];
	logic [pjd_pkg::JOB_W-1:0] rd_q;
	logic [CNT_BITS-1:0]       cnt_q;
	logic [CNT_BITS-1:0]       j_q;
	logic                      pass_q;
	logic [J_BITS-1:0]         last_urg_q, last_norm_q;
	logic                      has_norm_q;
	logic                      store_ok;

	assign store_ok = (cnt_q < CNT_BITS'(pjd_pkg::MAX_JOBS));

	always_ff @(posedge clk) begin
		if (cmd.load && store_ok)
			job_mem[cnt_q[J_BITS-1:0]] <= {s_tuser, s_tdata[REQ_W+MIN_W-1:0]};
		if (cmd.rd)
			rd_q <= job_mem[j_q[J_BITS-1:0]];
	end

	logic [REQ_W-1:0] rd_req;
	logic [MIN_W-1:0] rd_mins;
	logic             rd_urg;
	assign rd_req  = rd_q[REQ_W-1:0];
	assign rd_mins = rd_q[REQ_W+MIN_W-1:REQ_W];
	assign rd_urg  = rd_q[REQ_W+MIN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			j_q         <= '0;
			pass_q      <= 1'b0;
			last_urg_q  <= '0;
			last_norm_q <= '0;
			has_norm_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (store_ok) begin
					cnt_q <= cnt_q + 1'b1;
					if (s_tuser) last_urg_q <= cnt_q[J_BITS-1:0];
					else begin
						last_norm_q <= cnt_q[J_BITS-1:0];
						has_norm_q  <= 1'b1;
					end
				end
				if (s_tlast) begin
					j_q    <= '0;
					pass_q <= 1'b0;
				end
			end
			if (cmd.next_job) j_q <= j_q + 1'b1;
			if (cmd.next_pass) begin
				j_q    <= '0;
				pass_q <= 1'b1;
			end
			if (cmd.done) begin
				cnt_q      <= '0;
				has_norm_q <= 1'b0;
			end
		end
	end

	// worker state
	logic [TIME_W-1:0] free_q   [pjd_pkg::WORKERS];
	logic [EARN_W-1:0] earned_q [pjd_pkg::WORKERS];
	logic [W_BITS-1:0] w_q, best_q;
	logic [TIME_W-1:0] best_time_q;
	logic              w_last;
	logic              take;

	assign w_last = (w_q == W_BITS'(pjd_pkg::WORKERS - 1));
	// strict compare keeps the lowest index on ties
	assign take   = (w_q == '0) || (free_q[w_q] < best_time_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
		end else if ((cmd.load && s_tlast) || cmd.scan_start) begin
			w_q <= '0;
		end else if (cmd.init_step || cmd.scan_step) begin
			w_q <= w_last ? '0 : w_q + 1'b1;
		end
	end

	logic [TIME_W-1:0] start_q;
	logic [PROD_W-1:0] prod_q;
	logic [TIME_W:0]   fin_sum;
	logic [TIME_W-1:0] fin;
	logic [EARN_W:0]   earn_sum;
	logic [EARN_W-1:0] earn;
	logic              final_flag;

	assign fin_sum  = {1'b0, start_q} + (TIME_W+1)'(rd_mins);
	assign fin      = fin_sum[TIME_W] ? pjd_pkg::TIME_MAX : fin_sum[TIME_W-1:0];
	assign earn_sum = {1'b0, earned_q[best_q]} + (EARN_W+1)'(prod_q);
	assign earn     = earn_sum[EARN_W] ? pjd_pkg::EARN_MAX : earn_sum[EARN_W-1:0];
	assign final_flag = pass_q ? (j_q[J_BITS-1:0] == last_norm_q)
	                           : (!has_norm_q && (j_q[J_BITS-1:0] == last_urg_q));

	always_ff @(posedge clk) begin
		if (cmd.init_step) begin
			free_q[w_q]   <= TIME_W'(start_cfg_q);
			earned_q[w_q] <= '0;
		end
		if (cmd.scan_step && take) begin
			best_q      <= w_q;
			best_time_q <= free_q[w_q];
		end
		if (cmd.calc) begin
			start_q <= (best_time_q >= TIME_W'(rd_req)) ? best_time_q : TIME_W'(rd_req);
			prod_q  <= PROD_W'(rd_mins) * PROD_W'(rate_cfg_q);
		end
		if (cmd.upd) begin
			free_q[best_q]   <= fin;
			earned_q[best_q] <= earn;
			m_tdata <= {earn, pjd_pkg::WID_W'(best_q), fin, start_q, rd_req,
			            j_q[pjd_pkg::IDX_W-1:0]};
			m_tuser <= rd_urg;
			m_tlast <= final_flag;
		end
	end

	assign sts.at_end   = (j_q >= cnt_q);
	assign sts.pass1    = pass_q;
	assign sts.skip_job = pass_q ? rd_urg : !rd_urg;
	assign sts.w_last   = w_last;

endmodule
`default_nettype wire

// ----- hdl/priority_job_dispatch_earliest_free_top.sv -----
// sequence: each accepted request is stored while the job store has room; after the batch-end
// request, worker init, then per pass a read and check of each stored job and a pass restart at its end,
// plus per dispatched job a worker search, start/pay, update and output handoff
// throughput: set by the one-worker-per-cycle search loop and by output back-pressure, one job at a time
// reset: start time 780, pay rate 21, empty job store, ready to load
// top level; instantiates pjd_ctrl and pjd_dpath, uses pjd_pkg
`timescale 1ns / 1ps
`default_nettype none
module priority_job_dispatch_earliest_free_top (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire                                 cfg_index,
	input  wire  [pjd_pkg::CFG_W-1:0]           cfg_data,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// request_time[10:0], job_minutes[18:11], zero fill
	input  wire  [pjd_pkg::S_DATA_W-1:0]        s_tdata,
	// urgent
	input  wire                                 s_tuser,
	input  wire                                 s_tlast,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// job_index[4:0], job_request[15:5], start_minute[31:16],
	// finish_minute[47:32], worker_id[50:48], worker_earnings[71:51]
	output logic [pjd_pkg::M_DATA_W-1:0]        m_tdata,
	// was_urgent
	output logic                                m_tuser,
	output logic                                m_tlast
);

	pjd_pkg::pjd_cmd_t cmd;
	pjd_pkg::pjd_sts_t sts;

	assign cfg_ready = 1'b1;

	pjd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pjd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire
